FILE: hdl/infix_to_postfix_converter_defines.svh
// Assertion macros for the infix-to-postfix converter checker.
// Needs nothing else; taken in by the checker file.
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define I2P_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2p check failed");

// Next-cycle implication, disabled while reset is low.
`define I2P_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2p check failed");

`endif

FILE: hdl/i2p_pkg.sv
// Shared types, character codes and operator tables for the infix-to-postfix converter.
// No dependencies.
package i2p_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHAR,
        S_CONV,
        S_LAST,
        S_FLUSH,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_EQ   = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_MUL  = 3'd4,
        OP_DIV  = 3'd5,
        OP_LP   = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_MULTI_EQ     = 3'd1,
        ST_BAD_CHAR     = 3'd2,
        ST_UNMATCHED_R  = 3'd3,
        ST_UNMATCHED_L  = 3'd4,
        ST_NO_EQ        = 3'd5,
        ST_NOT_EQUALITY = 3'd6,
        ST_OVERFLOW     = 3'd7
    } t_status;

    typedef struct packed {
        logic [7:0] out_char;
        logic       token_end;
        logic       is_status;
        t_status    status_code;
    } t_result;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_ADD    = 8'h2B;
    localparam logic [7:0] CH_SUB    = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    function automatic logic [7:0] op_char(input t_op op);
        logic [7:0] c;
        case (op)
            OP_EQ:   c = CH_EQ;
            OP_ADD:  c = CH_ADD;
            OP_SUB:  c = CH_SUB;
            OP_MUL:  c = CH_MUL;
            OP_DIV:  c = CH_DIV;
            OP_LP:   c = CH_LPAREN;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] op_prec(input t_op op);
        logic [1:0] p;
        case (op)
            OP_ADD, OP_SUB: p = 2'd1;
            OP_MUL, OP_DIV: p = 2'd2;
            default:        p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic t_op char_to_op(input logic [7:0] c);
        t_op op;
        case (c)
            CH_EQ:     op = OP_EQ;
            CH_ADD:    op = OP_ADD;
            CH_SUB:    op = OP_SUB;
            CH_MUL:    op = OP_MUL;
            CH_LPAREN: op = OP_LP;
            default:   op = OP_DIV;
        endcase
        return op;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic t_result mk_token(input logic [7:0] c, input logic tend);
        t_result r;
        r.out_char    = c;
        r.token_end   = tend;
        r.is_status   = 1'b0;
        r.status_code = ST_OK;
        return r;
    endfunction

    function automatic t_result mk_status(input t_status code);
        t_result r;
        r.out_char    = 8'h00;
        r.token_end   = 1'b0;
        r.is_status   = 1'b1;
        r.status_code = code;
        return r;
    endfunction

endpackage

FILE: hdl/i2p_if.sv
// Valid/ready channel interfaces for the infix-to-postfix converter:
// character input channel and postfix result channel. No dependencies.
interface i2p_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface i2p_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       token_end;
    logic       is_status;
    logic [2:0] status_code;
    logic       last_of_run;

    modport source (output valid, output out_char, output token_end, output is_status,
                    output status_code, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input token_end, input is_status,
                    input status_code, input last_of_run, output ready);
endinterface

FILE: hdl/infix_to_postfix_converter.sv
// Shunting-yard converter: infix characters in, postfix characters and a status out.
// Sequencer over one operator stack memory with a registered top; uses i2p_pkg, i2p_if.
// Sequence: a character with no stack work passes S_CHAR, S_LAST and S_DONE, then S_IDLE,
//   the only state that takes a character; an operator also passes S_CONV, popping in turn.
// The last character also passes S_FLUSH for each operator flushed and for the status beat.
// Results pass staging then output register; emits wait while both are full and stalled.
// Reset: synchronous, active low; clears control and expression state, not the stack memory.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    i2p_in_if.sink         i_in,
    i2p_out_if.source      o_res
);

    localparam int CntW = $clog2(STACK_DEPTH + 1);
    localparam int IdxW = $clog2(STACK_DEPTH);

    i2p_pkg::t_state  r_state, n_state;
    logic [7:0]       r_ch, n_ch;
    logic             r_last, n_last;
    logic [CntW-1:0]  r_count, n_count;
    logic             r_seen_eq, n_seen_eq;
    logic [7:0]       r_held_char, n_held_char;
    logic             r_held_v, n_held_v;
    logic             r_err, n_err;
    i2p_pkg::t_status r_err_code, n_err_code;
    logic             r_lee, n_lee;
    i2p_pkg::t_status r_serr, n_serr;
    i2p_pkg::t_op     r_top;
    i2p_pkg::t_op     r_stack [STACK_DEPTH];

    logic             r_stg_v;
    i2p_pkg::t_result r_stg;
    logic             r_o_v;
    i2p_pkg::t_result r_o;
    logic             r_o_lol;

    logic             in_fire, out_free, stg_free;
    logic             c_go, c_more, c_emit, c_fin, c_push, c_mv;
    i2p_pkg::t_result c_res;
    i2p_pkg::t_op     c_push_op;
    i2p_pkg::t_op     cur_op;
    logic             w_is_ws, w_is_op, w_is_lp, w_is_rp, w_alnum, w_idcont, w_idstart;
    logic             w_full, w_held_out, w_top_pop;
    logic [CntW-1:0]  w_rd_cnt;
    logic [IdxW-1:0]  w_rd_idx;

    assign i_in.ready = (r_state == i2p_pkg::S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_o_v || o_res.ready;
    assign stg_free   = !r_stg_v || out_free;

    assign w_is_ws   = (r_ch == i2p_pkg::CH_SPACE) || (r_ch == i2p_pkg::CH_TAB);
    assign w_is_op   = r_ch inside {i2p_pkg::CH_EQ, i2p_pkg::CH_ADD, i2p_pkg::CH_SUB,
                                    i2p_pkg::CH_MUL, i2p_pkg::CH_DIV, i2p_pkg::CH_LPAREN,
                                    i2p_pkg::CH_RPAREN};
    assign w_is_lp   = (r_ch == i2p_pkg::CH_LPAREN);
    assign w_is_rp   = (r_ch == i2p_pkg::CH_RPAREN);
    assign w_alnum   = i2p_pkg::is_alnum(r_ch);
    assign w_idcont  = w_alnum || (r_ch == i2p_pkg::CH_UNDER) || (r_ch == i2p_pkg::CH_DOT);
    assign w_idstart = w_alnum || (r_ch == i2p_pkg::CH_UNDER) || (r_ch == i2p_pkg::CH_DOLLAR);
    assign cur_op    = i2p_pkg::char_to_op(r_ch);

    assign w_full     = (r_count == CntW'(STACK_DEPTH));
    assign w_held_out = r_held_v && (r_serr == i2p_pkg::ST_OK);
    // Pop while the top binds at least as tight; a right paren pops down to its match.
    assign w_top_pop  = (r_count != '0) && (r_top != i2p_pkg::OP_LP) &&
                        (w_is_rp || (i2p_pkg::op_prec(r_top) >= i2p_pkg::op_prec(cur_op)));

    // Action and next-value decode per sequencer state
    always_comb begin
        n_ch        = r_ch;
        n_last      = r_last;
        n_count     = r_count;
        n_seen_eq   = r_seen_eq;
        n_held_char = r_held_char;
        n_held_v    = r_held_v;
        n_err       = r_err;
        n_err_code  = r_err_code;
        n_lee       = r_lee;
        n_serr      = r_serr;
        c_go        = 1'b0;
        c_more      = 1'b0;
        c_emit      = 1'b0;
        c_fin       = 1'b0;
        c_push      = 1'b0;
        c_push_op   = cur_op;
        c_res       = i2p_pkg::mk_token(r_held_char, 1'b1);
        case (r_state)
            i2p_pkg::S_IDLE: begin
                c_go   = in_fire;
                n_ch   = i_in.ch;
                n_last = i_in.last;
            end
            i2p_pkg::S_CHAR: begin
                if (r_err) begin
                    c_go = 1'b1;
                end else begin
                    if (w_is_ws) begin
                        c_emit   = w_held_out;
                        n_held_v = 1'b0;
                    end else if (w_is_op) begin
                        c_emit   = w_held_out;
                        n_held_v = 1'b0;
                        if (r_ch == i2p_pkg::CH_EQ && r_seen_eq) begin
                            n_err      = 1'b1;
                            n_err_code = i2p_pkg::ST_MULTI_EQ;
                        end else begin
                            if (r_ch == i2p_pkg::CH_EQ) begin
                                n_seen_eq = 1'b1;
                            end
                            c_more = (r_serr == i2p_pkg::ST_OK);
                        end
                    end else if (r_held_v && w_idcont) begin
                        c_emit      = (r_serr == i2p_pkg::ST_OK);
                        c_res       = i2p_pkg::mk_token(r_held_char, 1'b0);
                        n_held_char = r_ch;
                    end else if (w_idstart) begin
                        c_emit      = w_held_out;
                        n_held_char = r_ch;
                        n_held_v    = 1'b1;
                    end else begin
                        n_err      = 1'b1;
                        n_err_code = i2p_pkg::ST_BAD_CHAR;
                        n_held_v   = 1'b0;
                    end
                    c_go = !c_emit || stg_free;
                end
            end
            i2p_pkg::S_CONV: begin
                if (w_is_lp) begin
                    c_go      = 1'b1;
                    c_push_op = i2p_pkg::OP_LP;
                    if (w_full) begin
                        n_serr = i2p_pkg::ST_OVERFLOW;
                    end else begin
                        c_push = 1'b1;
                    end
                end else if (w_top_pop) begin
                    c_emit  = 1'b1;
                    c_res   = i2p_pkg::mk_token(i2p_pkg::op_char(r_top), 1'b1);
                    n_count = r_count - CntW'(1);
                    c_more  = 1'b1;
                    c_go    = stg_free;
                end else if (w_is_rp) begin
                    c_go = 1'b1;
                    if (r_count == '0) begin
                        n_serr = i2p_pkg::ST_UNMATCHED_R;
                    end else begin
                        n_count = r_count - CntW'(1);
                    end
                end else begin
                    c_go = 1'b1;
                    if (w_full) begin
                        n_serr = i2p_pkg::ST_OVERFLOW;
                    end else begin
                        c_push = 1'b1;
                    end
                end
            end
            i2p_pkg::S_LAST: begin
                if (r_last && !r_err && r_held_v) begin
                    c_emit   = w_held_out;
                    n_held_v = 1'b0;
                    c_go     = !c_emit || stg_free;
                end else begin
                    c_go = 1'b1;
                end
            end
            i2p_pkg::S_FLUSH: begin
                c_emit = 1'b1;
                c_go   = stg_free;
                if (r_err) begin
                    c_res = i2p_pkg::mk_status(r_err_code);
                end else if (!r_seen_eq) begin
                    c_res = i2p_pkg::mk_status(i2p_pkg::ST_NO_EQ);
                end else if (r_serr != i2p_pkg::ST_OK) begin
                    c_res = i2p_pkg::mk_status(r_serr);
                end else if (r_count != '0 && r_top == i2p_pkg::OP_LP) begin
                    c_res = i2p_pkg::mk_status(i2p_pkg::ST_UNMATCHED_L);
                end else if (r_count != '0) begin
                    c_res   = i2p_pkg::mk_token(i2p_pkg::op_char(r_top), 1'b1);
                    n_count = r_count - CntW'(1);
                    c_more  = 1'b1;
                end else if (r_lee) begin
                    c_res = i2p_pkg::mk_status(i2p_pkg::ST_OK);
                end else begin
                    c_res = i2p_pkg::mk_status(i2p_pkg::ST_NOT_EQUALITY);
                end
                if (!c_more) begin
                    // Status closes the expression: drop all per-expression state
                    n_count     = '0;
                    n_seen_eq   = 1'b0;
                    n_held_char = 8'h00;
                    n_held_v    = 1'b0;
                    n_err       = 1'b0;
                    n_err_code  = i2p_pkg::ST_OK;
                    n_serr      = i2p_pkg::ST_OK;
                end
            end
            i2p_pkg::S_DONE: begin
                c_go  = !r_stg_v || out_free;
                c_fin = r_stg_v;
            end
            default: begin
                c_go = 1'b1;
            end
        endcase
        if (c_push) begin
            n_count = r_count + CntW'(1);
        end
        if (c_emit) begin
            n_lee = c_res.is_status ? 1'b0 : (c_res.out_char == i2p_pkg::CH_EQ);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            i2p_pkg::S_IDLE:  if (c_go) n_state = i2p_pkg::S_CHAR;
            i2p_pkg::S_CHAR:  if (c_go) n_state = c_more ? i2p_pkg::S_CONV : i2p_pkg::S_LAST;
            i2p_pkg::S_CONV:  if (c_go) n_state = c_more ? i2p_pkg::S_CONV : i2p_pkg::S_LAST;
            i2p_pkg::S_LAST:  if (c_go) n_state = r_last ? i2p_pkg::S_FLUSH : i2p_pkg::S_DONE;
            i2p_pkg::S_FLUSH: if (c_go) n_state = c_more ? i2p_pkg::S_FLUSH : i2p_pkg::S_DONE;
            i2p_pkg::S_DONE:  if (c_go) n_state = i2p_pkg::S_IDLE;
            default:          n_state = i2p_pkg::S_IDLE;
        endcase
    end

    // Staged beat moves out on the next emit, or marked last when the item is done
    assign c_mv     = c_go && ((c_emit && r_stg_v) || c_fin);
    assign w_rd_cnt = n_count - CntW'(1);
    assign w_rd_idx = w_rd_cnt[IdxW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= i2p_pkg::S_IDLE;
            r_count    <= '0;
            r_seen_eq  <= 1'b0;
            r_held_v   <= 1'b0;
            r_err      <= 1'b0;
            r_err_code <= i2p_pkg::ST_OK;
            r_lee      <= 1'b0;
            r_serr     <= i2p_pkg::ST_OK;
            r_stg_v    <= 1'b0;
            r_o_v      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (c_go) begin
                r_count    <= n_count;
                r_seen_eq  <= n_seen_eq;
                r_held_v   <= n_held_v;
                r_err      <= n_err;
                r_err_code <= n_err_code;
                r_lee      <= n_lee;
                r_serr     <= n_serr;
            end
            if (c_go && c_emit) begin
                r_stg_v <= 1'b1;
            end else if (c_go && c_fin) begin
                r_stg_v <= 1'b0;
            end
            if (c_mv) begin
                r_o_v <= 1'b1;
            end else if (o_res.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_go) begin
            r_ch        <= n_ch;
            r_last      <= n_last;
            r_held_char <= n_held_char;
        end
        if (c_go && c_emit) begin
            r_stg <= c_res;
        end
        if (c_mv) begin
            r_o     <= r_stg;
            r_o_lol <= c_fin;
        end
    end

    // Stack memory; the top is kept in a register, refreshed from the next count
    always_ff @(posedge i_clk) begin
        if (c_go && c_push) begin
            r_stack[r_count[IdxW-1:0]] <= c_push_op;
            r_top                      <= c_push_op;
        end else if (c_go) begin
            r_top <= r_stack[w_rd_idx];
        end
    end

    assign o_res.valid       = r_o_v;
    assign o_res.out_char    = r_o.out_char;
    assign o_res.token_end   = r_o.token_end;
    assign o_res.is_status   = r_o.is_status;
    assign o_res.status_code = r_o.status_code;
    assign o_res.last_of_run = r_o_lol;

endmodule

FILE: hdl/i2p_checker.sv
// Port-level checks for the infix-to-postfix converter, bound to the top level.
// Uses i2p_pkg and the assertion macros of infix_to_postfix_converter_defines.svh.
`include "infix_to_postfix_converter_defines.svh"

module i2p_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_token_end,
    input logic       i_is_status,
    input logic [2:0] i_status_code,
    input logic       i_last_of_run
);

    logic        w_status_shape;
    logic        w_code_clear;
    logic        w_stall;
    logic [13:0] w_beat;

    assign w_status_shape = i_last_of_run && (i_out_char == 8'h00) && !i_token_end;
    assign w_code_clear   = (i_status_code == i2p_pkg::ST_OK);
    assign w_stall        = i_out_valid && !i_out_ready;
    assign w_beat         = {i_out_char, i_token_end, i_is_status, i_status_code,
                             i_last_of_run};

    // Status always closes the run and carries no token character
    `I2P_ASSERT_NOW(a_status_closes, i_clk, i_rst_n, i_out_valid && i_is_status, w_status_shape)

    // Token beats carry a clear status code
    `I2P_ASSERT_NOW(a_token_code, i_clk, i_rst_n, i_out_valid && !i_is_status, w_code_clear)

    // Accepting a character drops input ready: the sequencer is busy with it before taking another
    `I2P_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // A stalled result beat holds
    `I2P_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, i_out_valid && $stable(w_beat))

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_char    (o_res.out_char),
    .i_token_end   (o_res.token_end),
    .i_is_status   (o_res.is_status),
    .i_status_code (o_res.status_code),
    .i_last_of_run (o_res.last_of_run)
);

FILE: tb/sv/tb_infix_to_postfix_converter.sv
`timescale 1ns / 100ps
// Self-checking bench for infix_to_postfix_converter: directed and random equations
// streamed in, every postfix and status beat checked against a shunting-yard predictor.
// Depends on infix_to_postfix_converter, i2p_pkg, i2p_in_if and i2p_out_if.
module tb_infix_to_postfix_converter;

    localparam int DEPTH       = 16;
    localparam int MAX_BEATS   = 34;
    localparam int RAND_CHARS  = 88;
    localparam int HOLD_CYCLES = 250;
    localparam int WATCH_LIMIT = 2000;
    localparam int TAIL_CYCLES = 24;

    localparam logic [7:0] CH_DIGIT0 = 8'h30;
    localparam logic [7:0] CH_UPPER  = 8'h41;
    localparam logic [7:0] CH_LOWER  = 8'h61;

    typedef struct packed {
        i2p_pkg::t_result res;
        logic             lor;
    } t_beat;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        logic       drain;
    } t_char_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2p_in_if  in_if ();
    i2p_out_if res_if ();

    infix_to_postfix_converter #(
        .STACK_DEPTH (DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state: one expression in flight
    logic [7:0]       sym_stack [DEPTH];
    int               sym_count;
    logic             eq_seen;
    logic [7:0]       held_ch;
    logic             held_ok;
    logic             chr_err;
    i2p_pkg::t_status chr_code;
    i2p_pkg::t_status stk_code;
    logic             eq_last;

    t_beat      step_q [$];
    t_beat      postfix_q [$];
    t_char_item pending_q [$];
    logic [7:0] draft [$];

    t_char_item next_item;
    t_beat      mon_got;
    t_beat      mon_want;
    int burst_left, gap_left, hold_left, phase_left, phase_mode;
    int dir_n, idle_cycles;
    int chars_taken   = 0;
    int beats_checked = 0;
    int expr_count    = 0;
    int mism_n        = 0;
    int status_tally [8] = '{default: 0};
    logic hold_done = 1'b0;

    function automatic logic alnum_byte(logic [7:0] c);
        return (c >= CH_DIGIT0 && c <= CH_DIGIT0 + 8'd9) ||
               (c >= CH_UPPER && c <= CH_UPPER + 8'd25) ||
               (c >= CH_LOWER && c <= CH_LOWER + 8'd25);
    endfunction

    function automatic logic is_op_sym(logic [7:0] c);
        return c == i2p_pkg::CH_EQ || c == i2p_pkg::CH_ADD || c == i2p_pkg::CH_SUB ||
               c == i2p_pkg::CH_MUL || c == i2p_pkg::CH_DIV || c == i2p_pkg::CH_LPAREN ||
               c == i2p_pkg::CH_RPAREN;
    endfunction

    function automatic int rank_of(logic [7:0] c);
        if (c == i2p_pkg::CH_MUL || c == i2p_pkg::CH_DIV)
            return 2;
        if (c == i2p_pkg::CH_ADD || c == i2p_pkg::CH_SUB)
            return 1;
        return 0;
    endfunction

    function automatic void clear_expr();
        foreach (sym_stack[i])
            sym_stack[i] = 8'h00;
        sym_count = 0;
        eq_seen   = 1'b0;
        held_ch   = 8'h00;
        held_ok   = 1'b0;
        chr_err   = 1'b0;
        chr_code  = i2p_pkg::ST_OK;
        stk_code  = i2p_pkg::ST_OK;
        eq_last   = 1'b0;
    endfunction

    function automatic void put_beat(logic [7:0] c, logic tend, logic stat,
                                     i2p_pkg::t_status code);
        t_beat b;
        if (step_q.size() >= MAX_BEATS)
            return;
        b.res.out_char    = c;
        b.res.token_end   = tend;
        b.res.is_status   = stat;
        b.res.status_code = code;
        b.lor             = 1'b0;
        step_q.push_back(b);
    endfunction

    // Token output stops once a stacking error is recorded
    function automatic void emit_tok(logic [7:0] c, logic tend);
        if (stk_code != i2p_pkg::ST_OK)
            return;
        put_beat(c, tend, 1'b0, i2p_pkg::ST_OK);
        eq_last = (c == i2p_pkg::CH_EQ);
    endfunction

    function automatic void close_ident();
        if (held_ok) begin
            emit_tok(held_ch, 1'b1);
            held_ok = 1'b0;
        end
    endfunction

    function automatic void push_sym(logic [7:0] c);
        if (sym_count >= DEPTH) begin
            stk_code = i2p_pkg::ST_OVERFLOW;
            return;
        end
        sym_stack[sym_count] = c;
        sym_count++;
    endfunction

    function automatic void shunt(logic [7:0] c);
        if (stk_code != i2p_pkg::ST_OK)
            return;
        if (c == i2p_pkg::CH_LPAREN) begin
            push_sym(c);
            return;
        end
        if (c == i2p_pkg::CH_RPAREN) begin
            while (sym_count > 0 && sym_stack[sym_count-1] != i2p_pkg::CH_LPAREN) begin
                emit_tok(sym_stack[sym_count-1], 1'b1);
                sym_count--;
            end
            if (sym_count == 0)
                stk_code = i2p_pkg::ST_UNMATCHED_R;
            else
                sym_count--;
            return;
        end
        while (sym_count > 0 && sym_stack[sym_count-1] != i2p_pkg::CH_LPAREN &&
               rank_of(sym_stack[sym_count-1]) >= rank_of(c)) begin
            emit_tok(sym_stack[sym_count-1], 1'b1);
            sym_count--;
        end
        push_sym(c);
    endfunction

    function automatic void char_fault(i2p_pkg::t_status code);
        chr_err  = 1'b1;
        chr_code = code;
        held_ok  = 1'b0;
    endfunction

    // Work out the beats caused by one accepted character and queue them
    function automatic void predict_char(logic [7:0] c, logic fin);
        i2p_pkg::t_status code;
        t_beat            b;
        step_q.delete();
        if (!chr_err) begin
            if (c == i2p_pkg::CH_SPACE || c == i2p_pkg::CH_TAB) begin
                close_ident();
            end else if (is_op_sym(c)) begin
                close_ident();
                if (c == i2p_pkg::CH_EQ && eq_seen) begin
                    char_fault(i2p_pkg::ST_MULTI_EQ);
                end else begin
                    if (c == i2p_pkg::CH_EQ)
                        eq_seen = 1'b1;
                    shunt(c);
                end
            end else if (held_ok && (alnum_byte(c) || c == i2p_pkg::CH_UNDER ||
                                     c == i2p_pkg::CH_DOT)) begin
                emit_tok(held_ch, 1'b0);
                held_ch = c;
            end else if (alnum_byte(c) || c == i2p_pkg::CH_UNDER ||
                         c == i2p_pkg::CH_DOLLAR) begin
                close_ident();
                held_ch = c;
                held_ok = 1'b1;
            end else begin
                char_fault(i2p_pkg::ST_BAD_CHAR);
            end
        end
        if (fin) begin
            if (chr_err) begin
                code = chr_code;
            end else begin
                close_ident();
                if (!eq_seen) begin
                    code = i2p_pkg::ST_NO_EQ;
                end else if (stk_code != i2p_pkg::ST_OK) begin
                    code = stk_code;
                end else begin
                    code = i2p_pkg::ST_OK;
                    while (sym_count > 0 && code == i2p_pkg::ST_OK) begin
                        if (sym_stack[sym_count-1] == i2p_pkg::CH_LPAREN) begin
                            code = i2p_pkg::ST_UNMATCHED_L;
                        end else begin
                            emit_tok(sym_stack[sym_count-1], 1'b1);
                            sym_count--;
                        end
                    end
                    if (code == i2p_pkg::ST_OK && !eq_last)
                        code = i2p_pkg::ST_NOT_EQUALITY;
                end
            end
            put_beat(8'h00, 1'b0, 1'b1, code);
            status_tally[code]++;
            expr_count++;
            clear_expr();
        end
        if (step_q.size() > 0) begin
            b = step_q.pop_back();
            b.lor = 1'b1;
            step_q.push_back(b);
        end
        foreach (step_q[i])
            postfix_q.push_back(step_q[i]);
    endfunction

    // Stimulus building
    function automatic void queue_text(logic drain);
        t_char_item it;
        foreach (draft[i]) begin
            it.ch    = draft[i];
            it.fin   = (i == draft.size() - 1);
            it.drain = drain && (i == 0);
            pending_q.push_back(it);
        end
        draft.delete();
    endfunction

    function automatic void queue_str(string s);
        for (int i = 0; i < s.len(); i++)
            draft.push_back(s[i]);
        queue_text(1'b0);
    endfunction

    function automatic logic [7:0] pick_alnum();
        case ($urandom_range(0, 2))
            0:       return CH_DIGIT0 + 8'($urandom_range(0, 9));
            1:       return CH_UPPER + 8'($urandom_range(0, 25));
            default: return CH_LOWER + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] pick_lead();
        case ($urandom_range(0, 9))
            0:       return i2p_pkg::CH_UNDER;
            1:       return i2p_pkg::CH_DOLLAR;
            default: return pick_alnum();
        endcase
    endfunction

    function automatic logic [7:0] pick_tail();
        case ($urandom_range(0, 9))
            0:       return i2p_pkg::CH_UNDER;
            1:       return i2p_pkg::CH_DOT;
            default: return pick_alnum();
        endcase
    endfunction

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 3))
            0:       return i2p_pkg::CH_ADD;
            1:       return i2p_pkg::CH_SUB;
            2:       return i2p_pkg::CH_MUL;
            default: return i2p_pkg::CH_DIV;
        endcase
    endfunction

    function automatic void maybe_space();
        if ($urandom_range(0, 4) == 0)
            draft.push_back($urandom_range(0, 1) ? i2p_pkg::CH_SPACE : i2p_pkg::CH_TAB);
    endfunction

    function automatic void add_ident();
        int n;
        n = $urandom_range(1, 3);
        draft.push_back(pick_lead());
        repeat (n - 1)
            draft.push_back(pick_tail());
    endfunction

    function automatic void add_operand(int depth);
        if (depth > 0 && $urandom_range(0, 3) == 0) begin
            draft.push_back(i2p_pkg::CH_LPAREN);
            add_expr(depth - 1);
            draft.push_back(i2p_pkg::CH_RPAREN);
        end else begin
            add_ident();
        end
    endfunction

    function automatic void add_expr(int depth);
        int terms;
        terms = $urandom_range(0, 2);
        add_operand(depth);
        repeat (terms) begin
            maybe_space();
            draft.push_back(pick_op());
            maybe_space();
            add_operand(depth);
        end
    endfunction

    function automatic void add_equation();
        add_ident();
        maybe_space();
        draft.push_back(i2p_pkg::CH_EQ);
        maybe_space();
        add_expr(2);
    endfunction

    function automatic void build_directed();
        queue_str("x.1\t=a-b/c$_*d");
        queue_str("(a=b)+ c");
        queue_str("==");
        queue_str("=)");
        queue_str("(=");
        queue_str("a");
        queue_str(".");
        draft.push_back(8'hFF);
        queue_text(1'b0);
        draft.push_back(8'h00);
        queue_text(1'b0);
    endfunction

    function automatic void build_random();
        int n_chars, k, kind, pos, nest;
        n_chars = 0;
        k = 0;
        while (n_chars < RAND_CHARS) begin
            kind = (k == 1) ? 9 : $urandom_range(0, 11);
            if (kind <= 6) begin
                add_equation();
            end else if (kind <= 8 || kind == 11) begin
                add_equation();
                pos = $urandom_range(0, draft.size() - 1);
                case ($urandom_range(0, 3))
                    0:       draft[pos] = i2p_pkg::CH_EQ;
                    1:       draft[pos] = i2p_pkg::CH_LPAREN;
                    2:       draft[pos] = i2p_pkg::CH_RPAREN;
                    default: draft[pos] = 8'($urandom_range(0, 255));
                endcase
            end else if (kind == 9) begin
                // Deep nesting: may fill the stack, or overflow past its depth
                nest = $urandom_range(14, 17);
                add_ident();
                draft.push_back(i2p_pkg::CH_EQ);
                repeat (nest)
                    draft.push_back(i2p_pkg::CH_LPAREN);
                add_ident();
                if ($urandom_range(0, 1))
                    repeat (nest)
                        draft.push_back(i2p_pkg::CH_RPAREN);
            end else begin
                repeat ($urandom_range(1, 4))
                    draft.push_back(8'($urandom_range(0, 255)));
            end
            n_chars += draft.size();
            queue_text(k == 0 || k % 6 == 3);
            k++;
        end
    endfunction

    function automatic string fmt_beat(t_beat b);
        return $sformatf("char=%h end=%b stat=%b code=%0d lor=%b", b.res.out_char,
                         b.res.token_end, b.res.is_status, b.res.status_code, b.lor);
    endfunction

    // Driver: bursts of beats with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.ch    <= 8'h00;
            in_if.last  <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
            clear_expr();
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_char(in_if.ch, in_if.last);
                chars_taken++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (pending_q.size() == 0 ||
                             (pending_q[0].drain && postfix_q.size() != 0 &&
                              hold_left == 0)) begin
                    in_if.valid <= 1'b0;
                end else begin
                    next_item = pending_q.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.ch    <= next_item.ch;
                    in_if.last  <= next_item.fin;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Monitor: check each result beat, drive ready on its own stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_left  = 0;
            phase_left = 0;
            phase_mode = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                mon_got.res.out_char    = res_if.out_char;
                mon_got.res.token_end   = res_if.token_end;
                mon_got.res.is_status   = res_if.is_status;
                mon_got.res.status_code = i2p_pkg::t_status'(res_if.status_code);
                mon_got.lor             = res_if.last_of_run;
                if (postfix_q.size() == 0) begin
                    mism_n++;
                    if (mism_n <= 10)
                        $display("unexpected beat: %s", fmt_beat(mon_got));
                end else begin
                    mon_want = postfix_q.pop_front();
                    if (mon_got.res.out_char !== mon_want.res.out_char ||
                        mon_got.res.token_end !== mon_want.res.token_end ||
                        mon_got.res.is_status !== mon_want.res.is_status ||
                        mon_got.res.status_code !== mon_want.res.status_code ||
                        mon_got.lor !== mon_want.lor) begin
                        mism_n++;
                        if (mism_n <= 10)
                            $display("beat %0d mismatch: expected %s, got %s", beats_checked,
                                     fmt_beat(mon_want), fmt_beat(mon_got));
                    end
                end
                beats_checked++;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (!hold_done && chars_taken >= dir_n + 40) begin
                // Hold off long enough for the block to back up into its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    phase_mode = $urandom_range(0, 2);
                    phase_left = $urandom_range(10, 60);
                end else begin
                    phase_left--;
                end
                case (phase_mode)
                    0:       res_if.ready <= 1'b1;
                    1:       res_if.ready <= 1'($urandom_range(0, 1));
                    default: res_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCH_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        build_directed();
        dir_n = pending_q.size();
        build_random();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_q.size() != 0 || in_if.valid)
            @(posedge i_clk);
        while (postfix_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d characters in %0d equations, %0d result beats checked",
                 chars_taken, expr_count, beats_checked);
        $display("Status counts ok/multi_eq/bad/unm_r/unm_l/no_eq/not_eq/ovf: %0d %0d %0d %0d",
                 status_tally[i2p_pkg::ST_OK], status_tally[i2p_pkg::ST_MULTI_EQ],
                 status_tally[i2p_pkg::ST_BAD_CHAR], status_tally[i2p_pkg::ST_UNMATCHED_R]);
        $display("  %0d %0d %0d %0d",
                 status_tally[i2p_pkg::ST_UNMATCHED_L], status_tally[i2p_pkg::ST_NO_EQ],
                 status_tally[i2p_pkg::ST_NOT_EQUALITY], status_tally[i2p_pkg::ST_OVERFLOW]);
        if (mism_n == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mism_n);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/i2p_pkg.sv
hdl/i2p_if.sv
hdl/infix_to_postfix_converter.sv
hdl/i2p_checker.sv
tb/sv/tb_infix_to_postfix_converter.sv
